FILE: hdl/elevator_stop_scheduler_top_defines.svh
// Assertion macros for the elevator stop scheduler top level.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ELEVATOR_STOP_SCHEDULER_TOP_DEFINES_SVH
`define ELEVATOR_STOP_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ESS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ESS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ess_pkg.sv
// Package for the elevator stop scheduler: sizes, codes and transaction types.
// No dependencies; imported by elevator_stop_scheduler_top.
`timescale 1ns / 1ps
`default_nettype none

package ess_pkg;

  localparam int STOP_SLOTS = 16;
  localparam int IDX_W      = $clog2(STOP_SLOTS);
  localparam int CNT_W      = $clog2(STOP_SLOTS + 1);
  localparam int ADDR_W     = $clog2(2 * STOP_SLOTS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic signed [7:0] LOWEST_RESET  = -8'sd2;
  localparam logic signed [7:0] HIGHEST_RESET = 8'sd7;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_TICK = 2'd1,
    KIND_DEST = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_UNEXP = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_LOWEST  = 2'd0,
    REG_HIGHEST = 2'd1,
    REG_RUN     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [7:0] floor;
    logic              kind;
  } stop_entry_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [7:0] floor;
    logic              call_direction;
    logic              stop_kind;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] floor_now;
    logic [1:0]        travel_direction;
    logic              moved;
    logic              arrived;
    logic              awaiting_destination;
    logic              accepted;
    logic [1:0]        status;
    logic [4:0]        up_pending;
    logic [4:0]        down_pending;
  } out_item_t;

  // True when a stored entry sorts after a new stop of floor f and kind k.
  function automatic logic goes_after(stop_entry_t e, logic signed [7:0] f, logic k);
    return (e.floor > f) || ((e.floor == f) && (e.kind > k));
  endfunction

endpackage

`default_nettype wire

FILE: hdl/elevator_stop_scheduler_top.sv
// Elevator stop scheduler: two sorted stop lists in one synchronous RAM, car state in flops.
// Most events go straight to the result; a tick that takes a list head reads it from RAM
// first, and a sorted insert walks its list from the tail, reading one list entry per cycle.
// A new transaction can be accepted in the cycle after the previous result is loaded.
// Synchronous active-high reset clears control state and lists.
`timescale 1ns / 1ps
`default_nettype none

`include "elevator_stop_scheduler_top_defines.svh"

module elevator_stop_scheduler_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ess_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ess_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [ess_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ess_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ess_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_INS_RD   = 7'b0000010,
    ST_INS_WALK = 7'b0000100,
    ST_INS_PUT  = 7'b0001000,
    ST_POP_RD   = 7'b0010000,
    ST_POP_TAKE = 7'b0100000,
    ST_OUT      = 7'b1000000
  } state_t;

  localparam logic [IDX_W:0]  SLOTS_WIDE = (IDX_W + 1)'(STOP_SLOTS);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(STOP_SLOTS - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STOP_SLOTS);

  // Configuration registers.
  logic signed [7:0] lowest_floor;
  logic signed [7:0] highest_floor;
  logic              run_enable;

  // Car state.
  logic signed [7:0] car_floor;
  logic signed [7:0] target_floor;
  dir_t              car_direction;
  logic              target_kind;
  logic              target_active;
  logic              waiting_destination;

  // Each list is a circular buffer in the RAM: the up list fills the lower half and
  // the down list the upper half. Popping the head only advances the head pointer,
  // so a sorted insert is the only operation that moves entries.
  logic [CNT_W-1:0] up_count;
  logic [CNT_W-1:0] down_count;
  logic [IDX_W-1:0] up_head;
  logic [IDX_W-1:0] down_head;

  // Sequencer registers. lsel picks the list being worked on (0 up, 1 down), and cur
  // is the position, counted from the head, of the entry under the read port.
  state_t           state;
  logic             lsel;
  logic [IDX_W-1:0] cur;
  stop_entry_t      ins_entry;
  logic             ins_dest;

  // Result flags gathered while the transaction is processed.
  logic    res_moved;
  logic    res_arrived;
  logic    res_accepted;
  status_t res_status;

  // Stop list RAM with a registered read port.
  stop_entry_t      mem [2 * STOP_SLOTS];
  logic [ADDR_W-1:0] mem_raddr;
  logic [ADDR_W-1:0] mem_waddr;
  stop_entry_t      mem_rdata;
  stop_entry_t      mem_wdata;
  logic             mem_we;

  // Combinational helpers.
  logic [CNT_W-1:0]  sel_count;
  logic [IDX_W-1:0]  sel_head;
  logic              add_sel;
  logic              add_kind;
  logic [CNT_W-1:0]  add_count;
  logic              add_in_range;
  logic              target_in_range;
  logic signed [7:0] step_floor;
  logic [CNT_W-1:0]  dir_count;
  logic              walk_after;
  logic              ins_done;

  // Maps a list select, its head and a position from the head to a RAM address.
  function automatic logic [ADDR_W-1:0] slot_addr(logic sel, logic [IDX_W-1:0] head,
                                                  logic [IDX_W-1:0] idx);
    logic [IDX_W:0]    sum;
    logic [IDX_W:0]    wrapped;
    logic [ADDR_W-1:0] base;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= SLOTS_WIDE) begin
      wrapped = sum - SLOTS_WIDE;
    end else begin
      wrapped = sum;
    end
    base = sel ? ADDR_W'(STOP_SLOTS) : '0;
    return base + ADDR_W'(wrapped);
  endfunction

  assign in_ready = (state == ST_IDLE);

  assign sel_count = lsel ? down_count : up_count;
  assign sel_head  = lsel ? down_head : up_head;

  // A destination goes to the up list when it lies above the car, else down.
  assign add_sel   = (kind_t'(in_data.kind) == KIND_DEST) ? !(in_data.floor > car_floor)
                                                          : in_data.call_direction;
  assign add_kind  = (kind_t'(in_data.kind) == KIND_DEST) ? 1'b1 : in_data.stop_kind;
  assign add_count = add_sel ? down_count : up_count;

  assign add_in_range    = (in_data.floor >= lowest_floor) && (in_data.floor <= highest_floor);
  assign target_in_range = (target_floor >= lowest_floor) && (target_floor <= highest_floor);

  always_comb begin
    if (car_floor == target_floor) begin
      step_floor = car_floor;
    end else if (target_floor > car_floor) begin
      step_floor = car_floor + 8'sd1;
    end else begin
      step_floor = car_floor - 8'sd1;
    end
  end

  assign dir_count = (car_direction == DIR_DOWN) ? down_count : up_count;

  // The insert walks from the tail toward the head. Each cycle the entry read in the
  // previous cycle is either shifted up one place or, once it sorts at or before the
  // new stop, the new stop is written just above it. Writes land one place above the
  // entry just read, so the read and write ports never touch the same entry.
  assign walk_after = goes_after(mem_rdata, ins_entry.floor, ins_entry.kind);
  assign ins_done   = (state == ST_INS_PUT) || ((state == ST_INS_WALK) && !walk_after);

  always_comb begin
    mem_raddr = slot_addr(lsel, sel_head, cur);
    if (state == ST_INS_WALK) begin
      mem_raddr = slot_addr(lsel, sel_head, cur - IDX_W'(1));
    end else if (state == ST_POP_RD) begin
      mem_raddr = slot_addr(lsel, sel_head, '0);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_addr(lsel, sel_head, cur);
    mem_wdata = ins_entry;
    if (state == ST_INS_WALK) begin
      mem_we    = 1'b1;
      mem_waddr = slot_addr(lsel, sel_head, cur + IDX_W'(1));
      mem_wdata = walk_after ? mem_rdata : ins_entry;
    end else if (state == ST_INS_PUT) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // Main sequencer. Every transaction ends in ST_OUT, which waits for the output
  // register to be free and then loads the result from the updated state.
  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_floor        <= LOWEST_RESET;
      highest_floor       <= HIGHEST_RESET;
      run_enable          <= 1'b1;
      car_floor           <= '0;
      target_floor        <= '0;
      car_direction       <= DIR_IDLE;
      target_kind         <= 1'b0;
      target_active       <= 1'b0;
      waiting_destination <= 1'b0;
      up_count            <= '0;
      down_count          <= '0;
      up_head             <= '0;
      down_head           <= '0;
      state               <= ST_IDLE;
      out_valid           <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_LOWEST:  lowest_floor  <= cfg_data;
          REG_HIGHEST: highest_floor <= cfg_data;
          REG_RUN:     run_enable    <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            res_moved    <= 1'b0;
            res_arrived  <= 1'b0;
            res_accepted <= 1'b0;
            res_status   <= STAT_OK;
            state        <= ST_OUT;
            unique case (kind_t'(in_data.kind))
              KIND_ADD, KIND_DEST: begin
                if ((kind_t'(in_data.kind) == KIND_DEST) && !waiting_destination) begin
                  res_status <= STAT_UNEXP;
                end else if (!add_in_range) begin
                  res_status <= STAT_RANGE;
                end else if (add_count >= FULL_COUNT) begin
                  res_status <= STAT_FULL;
                end else begin
                  lsel      <= add_sel;
                  ins_entry <= '{floor: in_data.floor, kind: add_kind};
                  ins_dest  <= (kind_t'(in_data.kind) == KIND_DEST);
                  if (add_count == '0) begin
                    cur   <= '0;
                    state <= ST_INS_PUT;
                  end else begin
                    cur   <= IDX_W'(add_count - CNT_W'(1));
                    state <= ST_INS_RD;
                  end
                end
              end
              KIND_TICK: begin
                if (run_enable && !waiting_destination) begin
                  if (target_active) begin
                    if (!target_in_range) begin
                      // The limits moved past the target: drop it.
                      target_active <= 1'b0;
                      car_direction <= DIR_IDLE;
                      res_status    <= STAT_RANGE;
                    end else begin
                      car_floor <= step_floor;
                      res_moved <= (car_floor != target_floor);
                      if (step_floor == target_floor) begin
                        res_arrived   <= 1'b1;
                        target_active <= 1'b0;
                        car_direction <= DIR_IDLE;
                        if (!target_kind) begin
                          waiting_destination <= 1'b1;
                        end
                      end
                    end
                  end else if ((car_direction == DIR_UP) || (car_direction == DIR_DOWN)) begin
                    if (dir_count == '0) begin
                      car_direction <= DIR_IDLE;
                    end else begin
                      lsel  <= (car_direction == DIR_DOWN);
                      state <= ST_POP_RD;
                    end
                  end else if (up_count != '0) begin
                    car_direction <= DIR_UP;
                  end else if (down_count != '0) begin
                    car_direction <= DIR_DOWN;
                  end else begin
                    car_direction <= DIR_IDLE;
                  end
                end
              end
              default: begin
                res_status <= STAT_UNEXP;
              end
            endcase
          end
        end
        ST_INS_RD: begin
          state <= ST_INS_WALK;
        end
        ST_INS_WALK: begin
          if (walk_after) begin
            if (cur == '0) begin
              state <= ST_INS_PUT;
            end else begin
              cur <= cur - IDX_W'(1);
            end
          end
        end
        ST_INS_PUT: begin
        end
        ST_POP_RD: begin
          state <= ST_POP_TAKE;
        end
        ST_POP_TAKE: begin
          target_floor  <= mem_rdata.floor;
          target_kind   <= mem_rdata.kind;
          target_active <= 1'b1;
          if (lsel) begin
            down_count <= down_count - CNT_W'(1);
            down_head  <= (down_head == LAST_SLOT) ? '0 : down_head + IDX_W'(1);
          end else begin
            up_count <= up_count - CNT_W'(1);
            up_head  <= (up_head == LAST_SLOT) ? '0 : up_head + IDX_W'(1);
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid                     <= 1'b1;
            out_data.floor_now            <= car_floor;
            out_data.travel_direction     <= car_direction;
            out_data.moved                <= res_moved;
            out_data.arrived              <= res_arrived;
            out_data.awaiting_destination <= waiting_destination;
            out_data.accepted             <= res_accepted;
            out_data.status               <= res_status;
            out_data.up_pending           <= 5'(up_count);
            out_data.down_pending         <= 5'(down_count);
            state                         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // The new stop has been written: the list grows by one.
      if (ins_done) begin
        if (lsel) begin
          down_count <= down_count + CNT_W'(1);
        end else begin
          up_count <= up_count + CNT_W'(1);
        end
        res_accepted <= 1'b1;
        if (ins_dest) begin
          waiting_destination <= 1'b0;
        end
        state <= ST_OUT;
      end
    end
  end

  // An insert only starts on a list with a free slot.
  `ESS_ASSERT_IMPLY(a_insert_has_room, (state == ST_INS_RD) || (state == ST_INS_PUT), sel_count < FULL_COUNT, "sorted insert running on a full stop list")
  // A live target always belongs to a direction and never coexists with a pending destination.
  `ESS_ASSERT_IMPLY(a_target_consistent, target_active, (car_direction != DIR_IDLE) && !waiting_destination, "active target without direction or while awaiting destination")
  // Every accepted transaction starts processing on the next cycle.
  `ESS_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state != ST_IDLE, "accepted transaction left the sequencer idle")

endmodule

`default_nettype wire

FILE: tb/elevator_stop_scheduler_top_test.sv
// Self-checking testbench for elevator_stop_scheduler_top: it drives stop, tick and destination
// transactions and predicts every result with its own model of the car and both stop lists.
// Depends on ess_pkg and the elevator_stop_scheduler_top RTL; it reads no files.
`timescale 1ns / 1ps

module elevator_stop_scheduler_top_test;
  import ess_pkg::*;

  // Kind code 3 is not a legal event. The block must answer it with an unexpected status.
  localparam logic [1:0] KIND_BOGUS = 2'd3;

  // Cycles allowed after the last result before the block counts as quiet. This covers the
  // longest sorted-insert walk over a full list.
  localparam int SETTLE_CYCLES = 2 * STOP_SLOTS + 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_item_t in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_item_t out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  elevator_stop_scheduler_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Car model. It holds its own copy of the limits, the run switch, both stop lists and the
  // car state, and it is advanced once per accepted input transaction.
  // ---------------------------------------------------------------------------------------
  logic signed [7:0] lim_lo = LOWEST_RESET;
  logic signed [7:0] lim_hi = HIGHEST_RESET;
  logic              run_on = 1'b1;

  // List 0 is the up list and list 1 the down list. Only entries below the count are read.
  logic signed [7:0] stop_floor [2][STOP_SLOTS];
  logic              stop_kind  [2][STOP_SLOTS];
  int                stop_cnt   [2] = '{0, 0};

  logic signed [7:0] car_pos    = 8'sd0;
  dir_t              car_dir    = DIR_IDLE;
  logic signed [7:0] goal_floor = 8'sd0;
  logic              goal_kind  = 1'b0;
  logic              goal_live  = 1'b0;
  logic              need_dest  = 1'b0;

  function automatic logic in_limits(logic signed [7:0] f);
    return (f >= lim_lo) && (f <= lim_hi);
  endfunction

  // Sorted insert: ascending by floor, hall calls ahead of car stops on the same floor, and
  // an equal entry lands behind the ones already held.
  function automatic status_t file_stop(int s, logic signed [7:0] f, logic k);
    int n;
    int pos;
    int i;
    n = stop_cnt[s];
    if (n >= STOP_SLOTS) return STAT_FULL;
    pos = 0;
    while (pos < n && (stop_floor[s][pos] < f ||
                       (stop_floor[s][pos] == f && stop_kind[s][pos] <= k)))
      pos++;
    for (i = n; i > pos; i--) begin
      stop_floor[s][i] = stop_floor[s][i-1];
      stop_kind[s][i]  = stop_kind[s][i-1];
    end
    stop_floor[s][pos] = f;
    stop_kind[s][pos]  = k;
    stop_cnt[s]        = n + 1;
    return STAT_OK;
  endfunction

  function automatic out_item_t advance_car(in_item_t ev);
    out_item_t         r;
    logic signed [7:0] fl;
    int                s;
    int                i;
    r  = '0;
    fl = ev.floor;
    case (ev.kind)
      KIND_ADD: begin
        if (!in_limits(fl)) r.status = STAT_RANGE;
        else r.status = file_stop(ev.call_direction ? 1 : 0, fl, ev.stop_kind);
        r.accepted = (r.status == STAT_OK);
      end
      KIND_TICK: begin
        // A tick does nothing while the run switch is off or a destination is owed.
        if (run_on && !need_dest) begin
          if (goal_live) begin
            if (!in_limits(goal_floor)) begin
              // The limits moved away from the target: drop it without arriving.
              goal_live = 1'b0;
              car_dir   = DIR_IDLE;
              r.status  = STAT_RANGE;
            end else begin
              if (car_pos != goal_floor) begin
                car_pos = (goal_floor > car_pos) ? car_pos + 8'sd1 : car_pos - 8'sd1;
                r.moved = 1'b1;
              end
              if (car_pos == goal_floor) begin
                r.arrived = 1'b1;
                goal_live = 1'b0;
                car_dir   = DIR_IDLE;
                if (!goal_kind) need_dest = 1'b1;
              end
            end
          end else if (car_dir != DIR_IDLE) begin
            s = (car_dir == DIR_UP) ? 0 : 1;
            if (stop_cnt[s] == 0) begin
              car_dir = DIR_IDLE;
            end else begin
              goal_floor = stop_floor[s][0];
              goal_kind  = stop_kind[s][0];
              goal_live  = 1'b1;
              for (i = 1; i < stop_cnt[s]; i++) begin
                stop_floor[s][i-1] = stop_floor[s][i];
                stop_kind[s][i-1]  = stop_kind[s][i];
              end
              stop_cnt[s]--;
            end
          end else if (stop_cnt[0] != 0) begin
            car_dir = DIR_UP;
          end else if (stop_cnt[1] != 0) begin
            car_dir = DIR_DOWN;
          end
        end
      end
      KIND_DEST: begin
        if (!need_dest) begin
          r.status = STAT_UNEXP;
        end else if (!in_limits(fl)) begin
          r.status = STAT_RANGE;
        end else begin
          // Destinations above the car go up, everything else goes down, always as car stops.
          r.status = file_stop((fl > car_pos) ? 0 : 1, fl, 1'b1);
          if (r.status == STAT_OK) begin
            r.accepted = 1'b1;
            need_dest  = 1'b0;
          end
        end
      end
      default: begin
        r.status = STAT_UNEXP;
      end
    endcase
    r.floor_now            = car_pos;
    r.travel_direction     = car_dir;
    r.awaiting_destination = need_dest;
    r.up_pending           = 5'(stop_cnt[0]);
    r.down_pending         = 5'(stop_cnt[1]);
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus plumbing. The initial block fills events_q; the driver drains it one
  // transaction at a time. due_results holds the predicted results in acceptance order.
  // ---------------------------------------------------------------------------------------
  in_item_t  events_q[$];
  out_item_t due_results[$];
  out_item_t head_want;
  logic      in_took = 1'b0;
  int        send_idle_pct = 0;
  int        stall_pct     = 0;
  int        hold_kick     = 0;
  int        hold_seen     = 0;
  int        hold_left     = 0;
  int        fails         = 0;
  int unsigned cycle_count = 0;

  // Input side: record each accepted transaction and predict its result right away.
  always @(posedge clk) begin
    in_took <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) due_results = {due_results, advance_car(in_data)};
  end

  // Driver. Valid is raised only at falling edges and held with a stable payload until the
  // transaction is taken. Idle gaps are drawn per cycle from send_idle_pct.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (events_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= events_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. A bump of hold_kick starts a long hold-off that this process counts down by
  // itself; otherwise ready drops at random per stall_pct.
  always @(negedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen = hold_kick;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_field(string nm, logic [7:0] w, logic [7:0] g);
    if (w !== g) $display("%0t ns: %s expected %0d, got %0d", $time, nm, w, g);
  endtask

  // Monitor. Every result transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t ns: result with no prediction waiting: expected none, got %h",
                 $time, out_data);
        fails++;
      end else begin
        head_want = due_results.pop_front();
        if (out_data !== head_want) begin
          $display("%0t ns: result mismatch: expected %h, got %h", $time, head_want, out_data);
          report_field("floor_now", head_want.floor_now, out_data.floor_now);
          report_field("travel_direction", 8'(head_want.travel_direction),
                       8'(out_data.travel_direction));
          report_field("moved", 8'(head_want.moved), 8'(out_data.moved));
          report_field("arrived", 8'(head_want.arrived), 8'(out_data.arrived));
          report_field("awaiting_destination", 8'(head_want.awaiting_destination),
                       8'(out_data.awaiting_destination));
          report_field("accepted", 8'(head_want.accepted), 8'(out_data.accepted));
          report_field("status", 8'(head_want.status), 8'(out_data.status));
          report_field("up_pending", 8'(head_want.up_pending), 8'(out_data.up_pending));
          report_field("down_pending", 8'(head_want.down_pending),
                       8'(out_data.down_pending));
          fails++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic offer(logic [1:0] k, logic [7:0] f, logic cd, logic sk);
    in_item_t it;
    it.kind           = k;
    it.floor          = f;
    it.call_direction = cd;
    it.stop_kind      = sk;
    events_q = {events_q, it};
  endtask

  // Mostly floors inside the current limits, with the just-outside floors, the extremes of
  // the field and fully random values mixed in.
  function automatic logic [7:0] pick_floor();
    int r;
    int lo;
    int hi;
    r  = $urandom_range(99);
    lo = lim_lo;
    hi = lim_hi;
    if (r < 75 && lo <= hi) return 8'(lo + $urandom_range(hi - lo));
    if (r < 85) return 8'(r[0] ? lo - 1 : hi + 1);
    if (r < 90) return r[0] ? 8'h7f : 8'h80;
    return 8'($urandom_range(255));
  endfunction

  // Random traffic: stop requests, destination entries and a few illegal kinds, with ticks
  // filling the rest so the car actually travels and serves its lists.
  task automatic queue_random(int n, int add_pct, int dest_pct);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < add_pct)
        offer(KIND_ADD, pick_floor(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      else if (r < add_pct + dest_pct)
        offer(KIND_DEST, pick_floor(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      else if (r < add_pct + dest_pct + 3)
        offer(KIND_BOGUS, 8'($urandom_range(255)), 1'($urandom_range(1)),
              1'($urandom_range(1)));
      else
        offer(KIND_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
              1'($urandom_range(1)));
    end
  endtask

  // Wait until every queued transaction is taken and every predicted result has come back,
  // then let the block settle before the next phase starts.
  task automatic drain();
    @(posedge clk);
    while (events_q.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only while the block is quiet; the model follows each one.
  task automatic write_reg(cfg_reg_t idx, logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_LOWEST:  lim_lo = val;
      REG_HIGHEST: lim_hi = val;
      REG_RUN:     run_on = val[0];
      default:     ;
    endcase
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with the reset limits of -2 to 7. Stops land in both lists, a hall call
    // and a car stop share floor 3 to check the ordering, and the floors just outside the
    // limits and at the ends of the field are refused.
    offer(KIND_ADD, 8'd7, 1'b0, 1'b0);
    offer(KIND_ADD, 8'hfe, 1'b1, 1'b1);
    offer(KIND_ADD, 8'd3, 1'b0, 1'b1);
    offer(KIND_ADD, 8'd3, 1'b0, 1'b0);
    offer(KIND_ADD, 8'd8, 1'b0, 1'b1);
    offer(KIND_ADD, 8'hfd, 1'b1, 1'b0);
    offer(KIND_ADD, 8'h7f, 1'b1, 1'b1);
    offer(KIND_ADD, 8'h80, 1'b0, 1'b0);
    // A destination nobody asked for, and an illegal kind.
    offer(KIND_DEST, 8'd5, 1'b0, 1'b0);
    offer(KIND_BOGUS, 8'hff, 1'b1, 1'b1);
    // Pick the up list, take the hall call at 3, climb there and stop to wait.
    repeat (5) offer(KIND_TICK, 8'h00, 1'b0, 1'b0);
    // A tick while a destination is owed changes nothing.
    offer(KIND_TICK, 8'hff, 1'b1, 1'b1);
    // An out-of-range destination is refused and the car keeps waiting; then one below.
    offer(KIND_DEST, 8'd100, 1'b0, 1'b0);
    offer(KIND_DEST, 8'd1, 1'b1, 1'b1);
    // The car stop at 3 is served where the car already stands: arrival without a move.
    repeat (3) offer(KIND_TICK, 8'h00, 1'b0, 1'b0);
    drain();

    // Reset limits, no idling on either side.
    queue_random(300, 30, 12);
    drain();

    // Widest limits; the sender idles about half the time.
    write_reg(REG_LOWEST, 8'h80);
    write_reg(REG_HIGHEST, 8'h7f);
    send_idle_pct = 47;
    stall_pct     = 0;
    queue_random(300, 35, 10);
    drain();

    // Narrow limits, so a target taken above may now be out of range. The receiver stalls
    // about half the time and opens with a long hold-off while the sender keeps offering,
    // which backs the block up into its input.
    write_reg(REG_LOWEST, 8'd0);
    write_reg(REG_HIGHEST, 8'd3);
    send_idle_pct = 0;
    stall_pct     = 47;
    hold_kick++;
    queue_random(300, 30, 12);
    drain();

    // Run switch off: ticks freeze the car while stop requests fill both lists to the top.
    write_reg(REG_RUN, 8'd0);
    write_reg(REG_LOWEST, 8'hfb);
    write_reg(REG_HIGHEST, 8'd5);
    send_idle_pct = 14;
    stall_pct     = 14;
    queue_random(100, 45, 10);
    drain();

    // Running again with the lowest limit above the highest: every floor is refused and each
    // stored target is dropped on its move tick.
    write_reg(REG_RUN, 8'd1);
    write_reg(REG_LOWEST, 8'd20);
    write_reg(REG_HIGHEST, 8'hec);
    queue_random(100, 30, 10);
    drain();

    // Both limits pinned at the top of the field.
    write_reg(REG_LOWEST, 8'h7f);
    write_reg(REG_HIGHEST, 8'h7f);
    send_idle_pct = 0;
    stall_pct     = 0;
    queue_random(150, 25, 12);
    drain();

    // Back to the reset limits with heavy stop traffic so the lists run full.
    write_reg(REG_LOWEST, 8'hfe);
    write_reg(REG_HIGHEST, 8'd7);
    send_idle_pct = 14;
    stall_pct     = 14;
    queue_random(300, 55, 12);
    drain();

    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/ess_pkg.sv
hdl/elevator_stop_scheduler_top.sv
tb/elevator_stop_scheduler_top_test.sv
